[design/mec_pkg.sv]
package mec_pkg;

   // Width and reset value of the iteration limit register.
   localparam int unsigned LIMIT_W     = 10;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd100;

   // Color channel width and full scale.
   localparam int unsigned COLOR_W  = 8;
   localparam logic [COLOR_W-1:0] CHAN_MAX = 8'd255;
   localparam logic [COLOR_W-1:0] CHAN_MIN = 8'd0;

   // Ramp index: floor(RAMP_SCALE * count / limit), at most RAMP_SCALE.
   localparam int unsigned RAMP_SCALE = 299;
   localparam int unsigned QUOT_W     = 9;
   localparam int unsigned NUM_W      = 19;
   localparam int unsigned SHIFT_W    = 4;
   localparam logic [SHIFT_W-1:0] QUOT_TOP = SHIFT_W'(QUOT_W - 1);

   // Ramp segments of SEG_SPAN steps each.
   localparam int unsigned SEG_SPAN = 60;
   localparam int unsigned SEG_W    = 3;
   localparam int unsigned FRAC_W   = 6;
   localparam logic [FRAC_W-1:0] FRAC_TOP = FRAC_W'(SEG_SPAN - 1);

   // Segment codes of the hue ramp.
   localparam logic [SEG_W-1:0] SEG_RED_UP    = 3'd0;
   localparam logic [SEG_W-1:0] SEG_GREEN_UP  = 3'd1;
   localparam logic [SEG_W-1:0] SEG_BLUE_UP   = 3'd2;
   localparam logic [SEG_W-1:0] SEG_MAGENTA   = 3'd3;
   localparam logic [SEG_W-1:0] SEG_BLUE_ONLY = 3'd4;

   // Reciprocal of 59 for floor(n / 59), exact for n below 33825.
   localparam int unsigned SCALED_W    = 14;
   localparam int unsigned RECIP_W     = 15;
   localparam int unsigned RECIP_SHIFT = 20;
   localparam logic [RECIP_W-1:0] RECIP_59 = 15'd17773;

   // Start of a segment on the ramp index scale.
   function automatic logic [QUOT_W-1:0] seg_base(input logic [SEG_W-1:0] seg);
      logic [QUOT_W-1:0] base;
      base = QUOT_W'(seg) * QUOT_W'(SEG_SPAN);
      return base;
   endfunction

   // Channel level floor(r * 255 / 59) for a step r within a segment.
   function automatic logic [COLOR_W-1:0] ramp_level(input logic [FRAC_W-1:0] r);
      logic [SCALED_W-1:0] scaled;
      logic [SCALED_W+RECIP_W-1:0] prod;
      scaled = {r, 8'b0} - SCALED_W'(r);
      prod   = (SCALED_W+RECIP_W)'(scaled) * (SCALED_W+RECIP_W)'(RECIP_59);
      return prod[RECIP_SHIFT +: COLOR_W];
   endfunction

endpackage

[design/mandelbrot_escape_color.sv]
// Mandelbrot escape-time unit with a hue-ramp color output.
// Command channel: an item (req_c_real, req_c_imag, signed fixed point with
// FRAC_BITS fraction bits) is taken at a rising edge with start high and busy
// low. Busy then stays high until the result has been produced.
// Result channel: rsp_valid is high for exactly one cycle while rsp_escape_count
// and rsp_red, rsp_green, rsp_blue hold the result; the receiver cannot stall,
// so the result must be captured in that cycle.
// Configuration: csr_write_enable writes csr_write_data into the iteration
// limit at the next rising edge; write it only while busy is low.
// Timing: one multiplier is shared by the three products of each iteration,
// so each iteration steps through ST_SQX, ST_SQY, ST_XY and ST_UPD. After the
// iterations the ramp index comes from a restoring divider that yields one
// quotient bit per cycle. One item is in flight at a time and the next one can
// be taken in the strobe cycle.
// Reset: synchronous, active high; returns to idle, drops busy and rsp_valid,
// and sets the iteration limit to 100.
module mandelbrot_escape_color #(
   parameter int unsigned COORD_WIDTH = 32,
   parameter int unsigned FRAC_BITS   = 28
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [COORD_WIDTH-1:0]     req_c_real,
   input  logic signed [COORD_WIDTH-1:0]     req_c_imag,
   output logic                              rsp_valid,
   output logic [mec_pkg::LIMIT_W-1:0]       rsp_escape_count,
   output logic [mec_pkg::COLOR_W-1:0]       rsp_red,
   output logic [mec_pkg::COLOR_W-1:0]       rsp_green,
   output logic [mec_pkg::COLOR_W-1:0]       rsp_blue,
   input  logic                              csr_write_enable,
   input  logic [mec_pkg::LIMIT_W-1:0]       csr_write_data
);
   import mec_pkg::*;

   // Iterate width, multiplier operand width and product width.
   localparam int unsigned ZW = COORD_WIDTH + 4;
   localparam int unsigned MW = FRAC_BITS + 2;
   localparam int unsigned PW = 2 * MW;

   localparam logic signed [ZW-1:0] TWO_Z     = ZW'(1) << (FRAC_BITS + 1);
   localparam logic signed [ZW-1:0] NEG_TWO_Z = -TWO_Z;
   localparam logic [PW:0] FOUR_P = (PW+1)'(1) << (2 * FRAC_BITS + 2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_XY,
      ST_UPD,
      ST_DIV,
      ST_SEG,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [LIMIT_W-1:0]           limit_ff, limit_in;
   logic signed [COORD_WIDTH-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic signed [ZW-1:0]          x_ff, x_in, y_ff, y_in;
   logic [LIMIT_W-1:0]           count_ff, count_in;
   logic signed [PW-1:0]          prod_ff, prod_in, xx_ff, xx_in, yy_ff, yy_in;
   logic [NUM_W-1:0]             rem_ff, rem_in;
   logic [QUOT_W-1:0]            quot_ff, quot_in;
   logic [SHIFT_W-1:0]           div_cnt_ff, div_cnt_in;
   logic [SEG_W-1:0]             seg_ff, seg_in;
   logic [FRAC_W-1:0]            frac_ff, frac_in;
   logic                         valid_ff, valid_in;
   logic [LIMIT_W-1:0]           out_count_ff, out_count_in;
   logic [COLOR_W-1:0]           red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   logic signed [MW-1:0]         mul_a, mul_b;
   logic signed [PW-1:0]         mul_p;
   logic                         z_in_range;
   logic [PW:0]                  sq_sum;
   logic signed [PW:0]           diff, diff_sh;
   logic signed [PW-1:0]         xy2_sh;
   logic signed [ZW-1:0]         x_next, y_next;
   logic [NUM_W-1:0]             trial;
   logic [COLOR_W-1:0]           level_up, level_down;

   // Shared multiplier: operands follow the step of the iteration.
   always_comb begin
      case (state_ff)
         ST_SQY: begin
            mul_a = y_ff[MW-1:0];
            mul_b = y_ff[MW-1:0];
         end
         ST_XY: begin
            mul_a = x_ff[MW-1:0];
            mul_b = y_ff[MW-1:0];
         end
         default: begin
            mul_a = x_ff[MW-1:0];
            mul_b = x_ff[MW-1:0];
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Escape tests and the floored update of z.
   assign z_in_range = (x_ff < TWO_Z) && (x_ff > NEG_TWO_Z) &&
                       (y_ff < TWO_Z) && (y_ff > NEG_TWO_Z);
   assign sq_sum  = {1'b0, xx_ff} + {1'b0, prod_ff};
   assign diff    = $signed({xx_ff[PW-1], xx_ff}) - $signed({yy_ff[PW-1], yy_ff});
   assign diff_sh = diff >>> FRAC_BITS;
   assign xy2_sh  = prod_ff >>> (FRAC_BITS - 1);
   assign x_next  = ZW'(diff_sh) + ZW'(cr_ff);
   assign y_next  = ZW'(xy2_sh) + ZW'(ci_ff);

   // Divider trial value and the two ramp levels.
   assign trial      = NUM_W'(limit_ff) << div_cnt_ff;
   assign level_up   = ramp_level(frac_ff);
   assign level_down = ramp_level(FRAC_TOP - frac_ff);

   // Next-state and datapath control.
   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      xx_in        = xx_ff;
      yy_in        = yy_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      div_cnt_in   = div_cnt_ff;
      seg_in       = seg_ff;
      frac_in      = frac_ff;
      valid_in     = 1'b0;
      out_count_in = out_count_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;

      if (csr_write_enable) begin
         limit_in = csr_write_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cr_in    = req_c_real;
               ci_in    = req_c_imag;
               x_in     = '0;
               y_in     = '0;
               count_in = '0;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            if (count_ff >= limit_ff || !z_in_range) begin
               state_in = ST_DIV;
            end else begin
               prod_in  = mul_p;
               state_in = ST_SQY;
            end
         end
         ST_SQY: begin
            xx_in    = prod_ff;
            prod_in  = mul_p;
            state_in = ST_XY;
         end
         ST_XY: begin
            if (sq_sum >= FOUR_P) begin
               state_in = ST_DIV;
            end else begin
               yy_in    = prod_ff;
               prod_in  = mul_p;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            x_in     = x_next;
            y_in     = y_next;
            count_in = count_ff + LIMIT_W'(1);
            state_in = ST_SQX;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Entry into the divider loads the numerator.
      if ((state_ff == ST_SQX && state_in == ST_DIV) ||
          (state_ff == ST_XY && state_in == ST_DIV)) begin
         rem_in     = NUM_W'(RAMP_SCALE) * NUM_W'(count_ff);
         quot_in    = '0;
         div_cnt_in = QUOT_TOP;
      end

      // Restoring division, one quotient bit per cycle.
      if (state_ff == ST_DIV) begin
         if (limit_ff != '0 && rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff - SHIFT_W'(1);
         state_in   = (div_cnt_ff == '0) ? ST_SEG : ST_DIV;
      end

      // Split the ramp index into segment and step.
      if (state_ff == ST_SEG) begin
         if (quot_ff >= QUOT_W'(4 * SEG_SPAN)) begin
            seg_in = SEG_BLUE_ONLY;
         end else if (quot_ff >= QUOT_W'(3 * SEG_SPAN)) begin
            seg_in = SEG_MAGENTA;
         end else if (quot_ff >= QUOT_W'(2 * SEG_SPAN)) begin
            seg_in = SEG_BLUE_UP;
         end else if (quot_ff >= QUOT_W'(SEG_SPAN)) begin
            seg_in = SEG_GREEN_UP;
         end else begin
            seg_in = SEG_RED_UP;
         end
         frac_in  = FRAC_W'(quot_ff - seg_base(seg_in));
         state_in = ST_OUT;
      end

      // Color mapping and the result strobe.
      if (state_ff == ST_OUT) begin
         valid_in     = 1'b1;
         out_count_in = count_ff;
         case (seg_ff)
            SEG_RED_UP: begin
               red_in   = CHAN_MAX;
               green_in = level_up;
               blue_in  = CHAN_MIN;
            end
            SEG_GREEN_UP: begin
               red_in   = level_down;
               green_in = CHAN_MAX;
               blue_in  = CHAN_MIN;
            end
            SEG_BLUE_UP: begin
               red_in   = CHAN_MIN;
               green_in = CHAN_MAX;
               blue_in  = level_up;
            end
            SEG_MAGENTA: begin
               red_in   = level_up;
               green_in = level_down;
               blue_in  = CHAN_MAX;
            end
            default: begin
               red_in   = level_down;
               green_in = CHAN_MIN;
               blue_in  = CHAN_MAX;
            end
         endcase
         state_in = ST_IDLE;
      end
   end

   // State, datapath and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         limit_ff <= LIMIT_RESET;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
         valid_ff <= valid_in;
      end
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      count_ff     <= count_in;
      prod_ff      <= prod_in;
      xx_ff        <= xx_in;
      yy_ff        <= yy_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      div_cnt_ff   <= div_cnt_in;
      seg_ff       <= seg_in;
      frac_ff      <= frac_in;
      out_count_ff <= out_count_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = valid_ff;
   assign rsp_escape_count = out_count_ff;
   assign rsp_red          = red_ff;
   assign rsp_green        = green_ff;
   assign rsp_blue         = blue_ff;

`ifndef SYNTH
   // An accepted item makes the unit busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // The result strobe lasts a single cycle.
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // Squarings only start on operands inside the escape radius box.
   a_operand_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQY) |-> $past(z_in_range))
      else $error("multiplier fed an out-of-range operand");

   // The divider counter never exceeds the index of the top quotient bit.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_cnt_ff <= QUOT_TOP))
      else $error("divider step count out of range");

   // Every ramp color has at least one channel at full scale.
   a_color_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red == CHAN_MAX || rsp_green == CHAN_MAX ||
                     rsp_blue == CHAN_MAX))
      else $error("ramp color without a full channel");
`endif

endmodule
